// ----- rtl/i2c_eeprom_transaction_sequencer_defines.svh -----
// Assertion macros for the I2C EEPROM transaction sequencer.
`ifndef I2C_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define I2CEES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("i2cees assertion failed");
// Implication checked in the same cycle outside reset.
`define I2CEES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cees implication failed");
`else
`define I2CEES_ASSERT(lbl, prop)
`define I2CEES_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/i2cees_pkg.sv -----
// Types and constants shared by the I2C EEPROM transaction sequencer.
package i2cees_pkg;

  localparam int unsigned MAX_LENGTH = 256;
  localparam int unsigned STEP_CAP   = MAX_LENGTH + 8;

  // Input actions.
  localparam logic [2:0] ACT_START_WR = 3'd0;
  localparam logic [2:0] ACT_START_RD = 3'd1;
  localparam logic [2:0] ACT_START_RR = 3'd2;
  localparam logic [2:0] ACT_EVENT    = 3'd3;
  localparam logic [2:0] ACT_LOAD     = 3'd4;

  // Sequencer modes.
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_WR      = 2'd1;
  localparam logic [1:0] MODE_RD      = 2'd2;
  localparam logic [1:0] MODE_RR      = 2'd3;

  // Bus commands.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_SEND  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;

  // Start status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_IDLE = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;
  localparam logic [1:0] ST_ZERO_LEN = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  typedef struct packed {
    logic [2:0] action;
    logic [8:0] length;
    logic [7:0] mem_address;
    logic       bus_busy;
    logic       stop_seen;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic [7:0] load_index;
    logic [7:0] load_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] start_status;
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       ack_last;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_data;
    logic       done_res;
  } rsp_t;

endpackage

// ----- rtl/i2c_eeprom_transaction_sequencer.sv -----
// I2C EEPROM transaction sequencer: step control, write buffer memory and result pipeline.
//
// Usage: the request channel (req_valid, req_stall, req) carries start requests,
// bus events and write buffer loads. Each accepted transaction yields exactly one
// response on the response channel (rsp_valid, rsp_stall, rsp), in order.
// The block takes one transaction per clock cycle while req_stall is low. After its
// request is accepted, a response passes the step decode and the write buffer read
// (a 256 x 8 synchronous memory with one read port and one write port), then the
// output register. The device address is written through the APB port at byte
// address 0 and reads back there; the user must write the port only while no
// transaction is in flight, since the block itself does not enforce this.
// Reset (synchronous, active high) returns the sequencer to idle, clears the step
// counter, length and target address, empties the pipeline and sets the device
// address to 80. The write buffer is not cleared: a load must precede any read of
// an entry. When the receiver stalls, the output register holds its response, the
// decode stage fills, and then req_stall rises until the output drains.
`include "i2c_eeprom_transaction_sequencer_defines.svh"
module i2c_eeprom_transaction_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  i2cees_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output i2cees_pkg::rsp_t   rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import i2cees_pkg::*;

  localparam logic [8:0] STEP_CAP_9 = 9'(STEP_CAP);
  localparam logic [8:0] MAX_LEN_9  = 9'(MAX_LENGTH);

  // Architectural state.
  logic [6:0] device_address;
  logic [1:0] mode, mode_next;
  logic [8:0] step_count, step_count_next;
  logic [8:0] transfer_length, transfer_length_next;
  logic [7:0] target_address, target_address_next;

  // Write buffer memory.
  logic [7:0] write_buffer [0:255];
  logic [7:0] mem_q;
  logic [7:0] rd_addr;

  // Decode stage and output register.
  logic       s1_valid;
  rsp_t       s1_res, s1_res_next;
  logic       s1_use_mem, s1_use_mem_next;
  rsp_t       s1_out;
  rsp_t       rsp_q;
  logic       rsp_vq;

  logic       req_acc;
  logic       s1_move;
  logic       cfg_wr;

  // Step decode helpers.
  logic [9:0] c10;
  logic [9:0] n10;
  logic [7:0] id_write;
  logic [7:0] id_read;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, device_address} : 32'd0;

  // Pipeline flow control: the decode stage moves whenever the output is free.
  assign s1_move   = s1_valid && (!rsp_vq || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign req_acc   = req_valid && !req_stall;
  assign rsp_valid = rsp_vq;
  assign rsp       = rsp_q;

  assign c10      = {1'b0, step_count};
  assign n10      = {1'b0, transfer_length};
  assign id_write = {device_address, 1'b0};
  assign id_read  = {device_address, 1'b1};

  // Step decode: next state and the result fields of one transaction.
  always_comb begin
    mode_next            = mode;
    step_count_next      = step_count;
    transfer_length_next = transfer_length;
    target_address_next  = target_address;
    s1_res_next          = '0;
    s1_use_mem_next      = 1'b0;
    rd_addr              = 8'(step_count - 9'd2);

    if (req.action inside {ACT_START_WR, ACT_START_RD, ACT_START_RR}) begin
      if (mode != MODE_STANDBY) begin
        s1_res_next.start_status = ST_NOT_IDLE;
      end else if (req.bus_busy) begin
        s1_res_next.start_status = ST_BUSY;
      end else if (req.length == 9'd0) begin
        s1_res_next.start_status = ST_ZERO_LEN;
      end else begin
        case (req.action)
          ACT_START_WR: mode_next = MODE_WR;
          ACT_START_RD: mode_next = MODE_RD;
          default:      mode_next = MODE_RR;
        endcase
        if (req.action != ACT_START_RD) begin
          target_address_next = req.mem_address;
        end
        transfer_length_next = (req.length > MAX_LEN_9) ? MAX_LEN_9 : req.length;
        step_count_next      = 9'd0;
        s1_res_next.bus_command = CMD_START;
      end
    end else if (req.action == ACT_EVENT && mode != MODE_STANDBY) begin
      if (req.stop_seen) begin
        // A stop on the final step hands over the last received byte.
        if ((mode == MODE_RD && c10 == n10 + 10'd2) ||
            (mode == MODE_RR && c10 == n10 + 10'd5)) begin
          s1_res_next.store_valid = 1'b1;
          s1_res_next.store_index = 8'(transfer_length - 9'd1);
          s1_res_next.store_data  = req.rx_byte;
        end
        mode_next = MODE_STANDBY;
        s1_res_next.done_res = 1'b1;
      end else begin
        if (step_count < STEP_CAP_9) begin
          step_count_next = step_count + 9'd1;
        end
        case (mode)
          MODE_WR: begin
            if (req.nack_seen) begin
              s1_res_next.bus_command = CMD_STOP;
            end else if (step_count == 9'd0) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = id_write;
            end else if (step_count == 9'd1) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = target_address;
            end else if (c10 <= n10 + 10'd1) begin
              // Data byte comes from the registered write buffer read in the next cycle.
              s1_res_next.bus_command = CMD_SEND;
              s1_use_mem_next         = 1'b1;
            end else begin
              s1_res_next.bus_command = CMD_STOP;
            end
          end
          MODE_RD: begin
            if (step_count == 9'd0) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = id_read;
            end else if (step_count == 9'd1) begin
              if (req.nack_seen) begin
                s1_res_next.bus_command = CMD_STOP;
              end else begin
                s1_res_next.bus_command = CMD_RECV;
                s1_res_next.ack_last    = (transfer_length == 9'd1);
              end
            end else if (c10 <= n10) begin
              s1_res_next.store_valid = 1'b1;
              s1_res_next.store_index = 8'(step_count - 9'd2);
              s1_res_next.store_data  = req.rx_byte;
              s1_res_next.ack_last    = (step_count == transfer_length);
            end else begin
              s1_res_next.bus_command = CMD_STOP;
            end
          end
          default: begin
            // Random read: address write, repeated start, then receive.
            if (step_count == 9'd0) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = id_write;
            end else if (step_count == 9'd1) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = target_address;
            end else if (step_count == 9'd2) begin
              s1_res_next.bus_command = CMD_START;
            end else if (step_count == 9'd3) begin
              s1_res_next.bus_command = CMD_SEND;
              s1_res_next.tx_byte     = id_read;
            end else if (step_count == 9'd4) begin
              if (req.nack_seen) begin
                s1_res_next.bus_command = CMD_STOP;
              end else begin
                s1_res_next.bus_command = CMD_RECV;
                s1_res_next.ack_last    = (transfer_length == 9'd1);
              end
            end else if (c10 <= n10 + 10'd3) begin
              s1_res_next.store_valid = 1'b1;
              s1_res_next.store_index = 8'(step_count - 9'd5);
              s1_res_next.store_data  = req.rx_byte;
              s1_res_next.ack_last    = (c10 == n10 + 10'd3);
            end else begin
              s1_res_next.bus_command = CMD_STOP;
            end
          end
        endcase
      end
    end
  end

  // Write buffer: a load writes at accept, a data step reads at accept.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      if (req.action == ACT_LOAD) begin
        write_buffer[req.load_index] <= req.load_byte;
      end
      mem_q <= write_buffer[rd_addr];
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= 7'd80;
      mode            <= MODE_STANDBY;
      step_count      <= '0;
      transfer_length <= '0;
      target_address  <= '0;
      s1_valid        <= 1'b0;
      rsp_vq          <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_DEVICE_ADDRESS) begin
        device_address <= pwdata[6:0];
      end
      if (req_acc) begin
        mode            <= mode_next;
        step_count      <= step_count_next;
        transfer_length <= transfer_length_next;
        target_address  <= target_address_next;
      end
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_vq <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_vq <= 1'b0;
      end
    end
  end

  // Decode stage result with the data byte merged in from the write buffer.
  always_comb begin
    s1_out = s1_res;
    if (s1_use_mem) begin
      s1_out.tx_byte = mem_q;
    end
  end

  // Payload registers of the two stages.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_res     <= s1_res_next;
      s1_use_mem <= s1_use_mem_next;
    end
    if (s1_move) begin
      rsp_q <= s1_out;
    end
  end

  `I2CEES_ASSERT(a_step_cap, step_count <= STEP_CAP_9)
  `I2CEES_ASSERT_IMP(a_done_idle, s1_valid && s1_res.done_res, mode == MODE_STANDBY)
  `I2CEES_ASSERT_IMP(a_full_stall, s1_valid && rsp_vq && rsp_stall, req_stall)
  `I2CEES_ASSERT_IMP(a_mem_send, s1_valid && s1_use_mem, s1_res.bus_command == CMD_SEND)

endmodule

// ----- dv/i2c_eeprom_transaction_sequencer_tb.sv -----
// Self-checking testbench for the I2C EEPROM transaction sequencer.
`timescale 1ns / 100ps

module i2c_eeprom_transaction_sequencer_tb;
  import i2cees_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 30;

  // Actions that the sequencer ignores.
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  // Shapes of a generated transfer.
  localparam int V_FULL     = 0;
  localparam int V_EARLY    = 1;
  localparam int V_NACK     = 2;
  localparam int V_OVERRUN  = 3;
  localparam int V_INTRUDE  = 4;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus queue and expected responses.
  req_t pending_requests[$];
  rsp_t predicted_steps[$];
  bit   buffer_loaded [256];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit          sender_hold = 1'b0;

  int unsigned queued_count = 0;
  int unsigned requests_accepted = 0;
  int unsigned responses_checked = 0;
  int unsigned completions = 0;
  int unsigned bytes_received = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: a shadow copy of the sequencer.
  logic [6:0] cfg_device_address = 7'd80;
  logic [1:0] seq_mode = MODE_STANDBY;
  logic [8:0] seq_step = '0;
  logic [8:0] seq_length = '0;
  logic [7:0] seq_target = '0;
  logic [7:0] page_buffer [256];

  i2c_eeprom_transaction_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Works out the response of one transaction and advances the shadow state.
  function automatic rsp_t predict_bus_step(input req_t t);
    rsp_t        r;
    int unsigned n;
    int unsigned c;
    int unsigned len;
    r = '0;
    n = seq_length;
    c = seq_step;
    if (t.action == ACT_START_WR || t.action == ACT_START_RD || t.action == ACT_START_RR) begin
      if (seq_mode != MODE_STANDBY) begin
        r.start_status = ST_NOT_IDLE;
      end else if (t.bus_busy) begin
        r.start_status = ST_BUSY;
      end else if (t.length == 0) begin
        r.start_status = ST_ZERO_LEN;
      end else begin
        len = (t.length > MAX_LENGTH) ? MAX_LENGTH : t.length;
        if (t.action == ACT_START_WR) seq_mode = MODE_WR;
        else if (t.action == ACT_START_RD) seq_mode = MODE_RD;
        else seq_mode = MODE_RR;
        // A plain read keeps the previous memory address.
        if (t.action != ACT_START_RD) seq_target = t.mem_address;
        seq_length = 9'(len);
        seq_step = '0;
        r.bus_command = CMD_START;
      end
    end else if (t.action == ACT_LOAD) begin
      page_buffer[t.load_index] = t.load_byte;
    end else if (t.action == ACT_EVENT && seq_mode != MODE_STANDBY) begin
      if (t.stop_seen) begin
        // The final byte is handed over only when the stop follows the last step.
        if ((seq_mode == MODE_RD && c == n + 2) || (seq_mode == MODE_RR && c == n + 5)) begin
          r.store_valid = 1'b1;
          r.store_index = 8'(n - 1);
          r.store_data = t.rx_byte;
        end
        seq_mode = MODE_STANDBY;
        r.done_res = 1'b1;
      end else begin
        case (seq_mode)
          MODE_WR: begin
            if (t.nack_seen) begin
              r.bus_command = CMD_STOP;
            end else if (c == 0) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = {cfg_device_address, 1'b0};
            end else if (c == 1) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = seq_target;
            end else if (c <= n + 1) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = page_buffer[8'(c - 2)];
            end else begin
              r.bus_command = CMD_STOP;
            end
          end
          MODE_RD: begin
            if (c == 0) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = {cfg_device_address, 1'b1};
            end else if (c == 1) begin
              if (t.nack_seen) begin
                r.bus_command = CMD_STOP;
              end else begin
                r.bus_command = CMD_RECV;
                r.ack_last = (n == 1);
              end
            end else if (c <= n) begin
              r.store_valid = 1'b1;
              r.store_index = 8'(c - 2);
              r.store_data = t.rx_byte;
              r.ack_last = (c == n);
            end else begin
              r.bus_command = CMD_STOP;
            end
          end
          default: begin
            // Random read: address write, repeated start, then receive.
            if (c == 0) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = {cfg_device_address, 1'b0};
            end else if (c == 1) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = seq_target;
            end else if (c == 2) begin
              r.bus_command = CMD_START;
            end else if (c == 3) begin
              r.bus_command = CMD_SEND;
              r.tx_byte = {cfg_device_address, 1'b1};
            end else if (c == 4) begin
              if (t.nack_seen) begin
                r.bus_command = CMD_STOP;
              end else begin
                r.bus_command = CMD_RECV;
                r.ack_last = (n == 1);
              end
            end else if (c <= n + 3) begin
              r.store_valid = 1'b1;
              r.store_index = 8'(c - 5);
              r.store_data = t.rx_byte;
              r.ack_last = (c == n + 3);
            end else begin
              r.bus_command = CMD_STOP;
            end
          end
        endcase
        // The step counter stops at its cap instead of wrapping.
        if (seq_step < STEP_CAP) seq_step = seq_step + 9'd1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      flag_error($sformatf("response %0d field %s: got %0h, expected %0h",
                           responses_checked, name, got, want));
    end
  endtask

  task automatic check_step(input rsp_t got, input rsp_t want);
    check_field("start_status", 8'(got.start_status), 8'(want.start_status));
    check_field("bus_command", 8'(got.bus_command), 8'(want.bus_command));
    check_field("tx_byte", got.tx_byte, want.tx_byte);
    check_field("ack_last", 8'(got.ack_last), 8'(want.ack_last));
    check_field("store_valid", 8'(got.store_valid), 8'(want.store_valid));
    check_field("store_index", got.store_index, want.store_index);
    check_field("store_data", got.store_data, want.store_data);
    check_field("done_res", 8'(got.done_res), 8'(want.done_res));
  endtask

  // Request driver: holds a stalled transaction, otherwise offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (!sender_hold && pending_requests.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        req <= pending_requests.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stall generator.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Monitor: checks responses, predicts accepted requests, and watches for a hang.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (predicted_steps.size() == 0) begin
          flag_error("response arrived with no transaction waiting");
        end else begin
          want = predicted_steps.pop_front();
          check_step(rsp, want);
        end
        if (rsp.done_res) completions++;
        if (rsp.store_valid) bytes_received++;
        responses_checked++;
      end
      if (req_valid && !req_stall) begin
        predicted_steps.push_back(predict_bus_step(req));
        requests_accepted++;
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One APB transfer to the device address register: setup, then access.
  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_DEVICE_ADDRESS, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_device_address();
    logic [31:0] readback;
    apb_access(1'b0, 32'd0, readback);
    if (readback[6:0] !== cfg_device_address) begin
      flag_error($sformatf("device address reads %0h, expected %0h",
                           readback[6:0], cfg_device_address));
    end
  endtask

  task automatic set_device_address(input logic [6:0] value);
    logic [31:0] unused_rdata;
    apb_access(1'b1, {25'd0, value}, unused_rdata);
    cfg_device_address = value;
    check_device_address();
  endtask

  function automatic req_t rand_req(input logic [2:0] act);
    logic [63:0] raw;
    req_t        t;
    raw = {$urandom, $urandom};
    t = raw[$bits(req_t)-1:0];
    t.action = act;
    return t;
  endfunction

  // Queues one item; a write that could start is preceded by loads of any buffer
  // entries it may send that were never written.
  task automatic queue_item(input req_t t);
    req_t        fill;
    int unsigned n;
    if (t.action == ACT_START_WR && t.length != 0 && !t.bus_busy) begin
      n = (t.length > MAX_LENGTH) ? MAX_LENGTH : t.length;
      for (int i = 0; i < n; i++) begin
        if (!buffer_loaded[i]) begin
          fill = rand_req(ACT_LOAD);
          fill.load_index = 8'(i);
          pending_requests.push_back(fill);
          buffer_loaded[i] = 1'b1;
          queued_count++;
        end
      end
    end
    if (t.action == ACT_LOAD) buffer_loaded[t.load_index] = 1'b1;
    pending_requests.push_back(t);
    queued_count++;
  endtask

  // A start followed by bus events, ending with a stop event.
  task automatic queue_transfer(input logic [2:0] act, input logic [8:0] len,
                                input int variant, input int unsigned extra);
    req_t        t;
    req_t        stray;
    int unsigned n;
    int unsigned steps;
    int unsigned nack_step;
    int unsigned cut;
    int unsigned pick;
    n = (len > MAX_LENGTH) ? MAX_LENGTH : len;
    if (act == ACT_START_WR) steps = n + 3;
    else if (act == ACT_START_RD) steps = n + 2;
    else steps = n + 5;
    if (act == ACT_START_WR) nack_step = $urandom_range(steps - 1);
    else if (act == ACT_START_RD) nack_step = 1;
    else nack_step = 4;
    cut = steps;
    if (variant == V_EARLY) cut = $urandom_range(steps - 1);
    if (variant == V_OVERRUN) cut = steps + extra;
    t = rand_req(act);
    t.length = len;
    t.bus_busy = 1'b0;
    queue_item(t);
    for (int s = 0; s < cut; s++) begin
      // A start or a load in the middle of a transfer.
      if (variant == V_INTRUDE && s == cut / 2) begin
        pick = $urandom_range(3);
        stray = rand_req((pick == 3) ? ACT_LOAD : 3'(pick));
        stray.length = 9'($urandom_range(16));
        queue_item(stray);
      end
      t = rand_req(ACT_EVENT);
      t.stop_seen = 1'b0;
      if (act == ACT_START_WR || s == nack_step) t.nack_seen = 1'b0;
      if (variant == V_NACK && s == nack_step) begin
        t.nack_seen = 1'b1;
        queue_item(t);
        break;
      end
      queue_item(t);
    end
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b1;
    queue_item(t);
  endtask

  // Mostly well-formed transfers with random content, the rest stray items.
  task automatic queue_random_phase(input int unsigned budget);
    req_t        t;
    int unsigned stop_at;
    int unsigned v;
    logic [8:0]  len;
    stop_at = queued_count + budget;
    while (queued_count < stop_at) begin
      if ($urandom_range(99) < 78) begin
        v = $urandom_range(7);
        len = ($urandom_range(9) == 0) ? 9'($urandom_range(9, 40)) : 9'($urandom_range(1, 8));
        queue_transfer(3'($urandom_range(2)), len, (v > 4) ? V_FULL : int'(v),
                       $urandom_range(1, 4));
      end else begin
        t = rand_req(3'($urandom_range(ACT_UNUSED_HI)));
        if (t.action <= ACT_START_RR) begin
          t.bus_busy = ($urandom_range(9) < 7);
          if (!t.bus_busy) begin
            t.length = ($urandom_range(3) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
          end
        end
        queue_item(t);
      end
    end
  endtask

  task automatic queue_directed();
    req_t t;
    // Events and unused actions while idle; a stop in idle reports no completion.
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b1;
    queue_item(t);
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b0;
    queue_item(t);
    queue_item(rand_req(ACT_UNUSED_LO));
    queue_item(rand_req(ACT_UNUSED_HI));
    // Refused starts: bus busy, then zero length.
    t = rand_req(ACT_START_RD);
    t.bus_busy = 1'b1;
    t.length = 9'h1FF;
    queue_item(t);
    t = rand_req(ACT_START_WR);
    t.bus_busy = 1'b0;
    t.length = 9'd0;
    queue_item(t);
    // Buffer extremes.
    t = rand_req(ACT_LOAD);
    t.load_index = 8'h00;
    t.load_byte = 8'hFF;
    queue_item(t);
    t = rand_req(ACT_LOAD);
    t.load_index = 8'hFF;
    t.load_byte = 8'h00;
    queue_item(t);
    // One-byte plain read with a refused start inside and an ignored nack.
    t = rand_req(ACT_START_RD);
    t.bus_busy = 1'b0;
    t.length = 9'd1;
    queue_item(t);
    t = rand_req(ACT_START_RR);
    t.bus_busy = 1'b0;
    t.length = 9'h100;
    queue_item(t);
    for (int s = 0; s < 3; s++) begin
      t = rand_req(ACT_EVENT);
      t.stop_seen = 1'b0;
      t.nack_seen = (s == 0);
      t.rx_byte = 8'hFF;
      queue_item(t);
    end
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b1;
    t.rx_byte = 8'hFF;
    queue_item(t);
    // One-byte page write at the top memory address.
    t = rand_req(ACT_START_WR);
    t.bus_busy = 1'b0;
    t.length = 9'd1;
    t.mem_address = 8'hFF;
    queue_item(t);
    repeat (4) begin
      t = rand_req(ACT_EVENT);
      t.stop_seen = 1'b0;
      t.nack_seen = 1'b0;
      queue_item(t);
    end
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b1;
    queue_item(t);
    // Random read refused at the receive switch; the stop wins over a nack.
    t = rand_req(ACT_START_RR);
    t.bus_busy = 1'b0;
    t.length = 9'd2;
    t.mem_address = 8'h00;
    queue_item(t);
    for (int s = 0; s < 5; s++) begin
      t = rand_req(ACT_EVENT);
      t.stop_seen = 1'b0;
      t.nack_seen = (s == 4);
      queue_item(t);
    end
    t = rand_req(ACT_EVENT);
    t.stop_seen = 1'b1;
    t.nack_seen = 1'b1;
    queue_item(t);
  endtask

  // Waits until every queued transaction is accepted and answered, then lets the
  // two-stage pipeline settle.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_valid || predicted_steps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    check_device_address();

    // Directed cases with the reset device address; the sender idles often while
    // the receiver stalls more.
    @(negedge clk);
    sender_idle_pct = 37;
    receiver_stall_pct = 60;
    queue_directed();
    wait_until_drained();

    // Same rates with random traffic; one full pause midway.
    set_device_address(7'h7F);
    @(negedge clk);
    sender_idle_pct = 37;
    receiver_stall_pct = 60;
    queue_random_phase(100);
    do @(negedge clk); while (pending_requests.size() > 50);
    sender_hold = 1'b1;
    do @(negedge clk); while (req_valid || predicted_steps.size() != 0);
    sender_hold = 1'b0;
    wait_until_drained();

    // Rates swapped.
    set_device_address(7'h00);
    @(negedge clk);
    sender_idle_pct = 60;
    receiver_stall_pct = 37;
    queue_random_phase(100);
    wait_until_drained();

    // Full rate, with a clipped maximum-length read and a long step overrun.
    set_device_address(7'($urandom_range(1, 126)));
    @(negedge clk);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    queue_transfer(ACT_START_RR, 9'h1FF, V_FULL, 0);
    queue_random_phase(80);
    queue_transfer(ACT_START_RD, 9'd1, V_OVERRUN, 270);
    wait_until_drained();

    if (predicted_steps.size() != 0) begin
      flag_error($sformatf("%0d responses never arrived", predicted_steps.size()));
    end
    $display("Run covered %0d transactions and %0d checked responses over four device",
             requests_accepted, responses_checked);
    $display("addresses, with %0d completed bus transfers and %0d received bytes.",
             completions, bytes_received);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
